// ----- hdl/mqlf_pkg.sv -----
package mqlf_pkg;

    localparam int DEF_NUM_QUEUES = 16;
    localparam int DEF_POOL_DEPTH = 256;
    localparam int DEF_KEY_WIDTH  = 32;

    localparam int FUNC_W   = 1;
    localparam int QIDX_W   = 4;
    localparam int QIDX_N   = 1 << QIDX_W;
    localparam int KEY_IN_W = 32;
    localparam int STATUS_W = 2;

    typedef enum logic [FUNC_W-1:0] {
        FN_PUSH = 1'b0,
        FN_POP  = 1'b1
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_DONE  = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    typedef enum logic [0:0] {
        CS_IDLE,
        CS_EXEC
    } ctrl_state_t;

    typedef struct packed {
        logic capture;
        logic exec;
    } mqlf_cmd_t;

    typedef struct packed {
        logic out_valid;
    } mqlf_stat_t;

endpackage

// ----- hdl/mqlf_req_if.sv -----
interface mqlf_req_if import mqlf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic [FUNC_W-1:0]          func;
    logic [QIDX_W-1:0]          queue_index;
    logic signed [KEY_IN_W-1:0] key;

    modport source (output valid, func, queue_index, key, input ready);
    modport sink   (input valid, func, queue_index, key, output ready);

endinterface

// ----- hdl/mqlf_rsp_if.sv -----
interface mqlf_rsp_if import mqlf_pkg::*; ();

    logic                       valid;
    logic                       ready;
    logic signed [KEY_IN_W-1:0] popped_key;
    logic [STATUS_W-1:0]        status;

    modport source (output valid, popped_key, status, input ready);
    modport sink   (input valid, popped_key, status, output ready);

endinterface

// ----- hdl/mqlf_ram.sv -----
module mqlf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                                 clk,
    input  logic                                 we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                     wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                     rdata
);

    logic [WIDTH-1:0] mem [0:DEPTH-1];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- hdl/mqlf_ctrl.sv -----
module mqlf_ctrl import mqlf_pkg::*; (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    input  logic       out_ready,
    input  mqlf_stat_t stat,
    output mqlf_cmd_t  cmd
);

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    logic        slot_free;

    // output register is free now or drains at this edge
    assign slot_free = !stat.out_valid || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= CS_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            CS_IDLE:
            begin
                if (in_valid && slot_free)
                begin
                    state_next = CS_EXEC;
                end
            end
            CS_EXEC:
            begin
                state_next = CS_IDLE;
            end
            default:
            begin
                state_next = CS_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.exec    = 1'b0;
        case (state_reg)
            CS_IDLE:
            begin
                in_ready    = slot_free;
                cmd.capture = in_valid && slot_free;
            end
            CS_EXEC:
            begin
                cmd.exec = 1'b1;
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

// ----- hdl/mqlf_dp.sv -----
module mqlf_dp import mqlf_pkg::*; #(
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  mqlf_cmd_t                  cmd,
    output mqlf_stat_t                 stat,
    input  logic [FUNC_W-1:0]          in_func,
    input  logic [QIDX_W-1:0]          in_queue_index,
    input  logic signed [KEY_IN_W-1:0] in_key,
    input  logic                       out_ready,
    output logic                       out_valid,
    output logic signed [KEY_IN_W-1:0] out_popped_key,
    output logic [STATUS_W-1:0]        out_status
);

    localparam int QW = (NUM_QUEUES > 1) ? $clog2(NUM_QUEUES) : 1;
    localparam int PW = $clog2(POOL_DEPTH);
    localparam int CW = $clog2(POOL_DEPTH + 1);

    logic [QW-1:0] qmap [0:QIDX_N-1];

    logic [PW-1:0]         head_reg [0:NUM_QUEUES-1];
    logic [PW-1:0]         head_next [0:NUM_QUEUES-1];
    logic [PW-1:0]         tail_reg [0:NUM_QUEUES-1];
    logic [PW-1:0]         tail_next [0:NUM_QUEUES-1];
    logic [NUM_QUEUES-1:0] nonempty_reg;
    logic [NUM_QUEUES-1:0] nonempty_next;
    logic [PW-1:0]         free_head_reg;
    logic [PW-1:0]         free_head_next;
    logic [CW-1:0]         free_count_reg;
    logic [CW-1:0]         free_count_next;
    logic [CW-1:0]         fresh_count_reg;
    logic [CW-1:0]         fresh_count_next;

    func_t                 op_func_reg;
    logic [QW-1:0]         op_q_reg;
    logic [KEY_WIDTH-1:0]  op_key_reg;

    logic                  out_valid_reg;
    logic [KEY_IN_W-1:0]   out_key_reg;
    status_t               out_status_reg;

    logic [QW-1:0]         in_q;
    logic [KEY_WIDTH-1:0]  in_key_kw;
    logic [PW-1:0]         rd_addr;
    logic [KEY_WIDTH-1:0]  key_rdata;
    logic [PW-1:0]         next_rdata;
    logic [KEY_IN_W-1:0]   pop_key_ext;

    logic                  key_we;
    logic [PW-1:0]         key_waddr;
    logic                  next_we;
    logic [PW-1:0]         next_waddr;
    logic [PW-1:0]         next_wdata;
    logic [KEY_IN_W-1:0]   res_key;
    status_t               res_status;
    logic [PW-1:0]         node;
    logic                  got;

    genvar gi;
    generate
        for (gi = 0; gi < QIDX_N; gi++)
        begin : g_qmap
            assign qmap[gi] = QW'(gi % NUM_QUEUES);
        end

        if (KEY_WIDTH > KEY_IN_W)
        begin : g_key_wide
            assign in_key_kw   = {{(KEY_WIDTH - KEY_IN_W){1'b0}}, in_key};
            assign pop_key_ext = key_rdata[KEY_IN_W-1:0];
        end
        else if (KEY_WIDTH == KEY_IN_W)
        begin : g_key_same
            assign in_key_kw   = in_key;
            assign pop_key_ext = key_rdata;
        end
        else
        begin : g_key_narrow
            assign in_key_kw   = in_key[KEY_WIDTH-1:0];
            assign pop_key_ext = {{(KEY_IN_W - KEY_WIDTH){key_rdata[KEY_WIDTH-1]}}, key_rdata};
        end
    endgenerate

    assign in_q    = qmap[in_queue_index];
    assign rd_addr = (in_func == FN_POP) ? head_reg[in_q] : free_head_reg;

    mqlf_ram #(
        .WIDTH (KEY_WIDTH),
        .DEPTH (POOL_DEPTH)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (key_waddr),
        .wdata (op_key_reg),
        .raddr (rd_addr),
        .rdata (key_rdata)
    );

    mqlf_ram #(
        .WIDTH (PW),
        .DEPTH (POOL_DEPTH)
    ) u_next_ram (
        .clk   (clk),
        .we    (next_we),
        .waddr (next_waddr),
        .wdata (next_wdata),
        .raddr (rd_addr),
        .rdata (next_rdata)
    );

    // a new tail's link is written only when the next push links behind it
    always_comb
    begin
        head_next        = head_reg;
        tail_next        = tail_reg;
        nonempty_next    = nonempty_reg;
        free_head_next   = free_head_reg;
        free_count_next  = free_count_reg;
        fresh_count_next = fresh_count_reg;
        key_we           = 1'b0;
        key_waddr        = '0;
        next_we          = 1'b0;
        next_waddr       = '0;
        next_wdata       = '0;
        res_key          = '0;
        res_status       = ST_DONE;
        node             = '0;
        got              = 1'b0;
        if (op_func_reg == FN_PUSH)
        begin
            if (free_count_reg != '0)
            begin
                got             = 1'b1;
                node            = free_head_reg;
                free_head_next  = next_rdata;
                free_count_next = free_count_reg - 1'b1;
            end
            else if (fresh_count_reg < CW'(POOL_DEPTH))
            begin
                got              = 1'b1;
                node             = fresh_count_reg[PW-1:0];
                fresh_count_next = fresh_count_reg + 1'b1;
            end
            if (got)
            begin
                key_we    = cmd.exec;
                key_waddr = node;
                if (nonempty_reg[op_q_reg])
                begin
                    next_we    = cmd.exec;
                    next_waddr = tail_reg[op_q_reg];
                    next_wdata = node;
                end
                else
                begin
                    head_next[op_q_reg] = node;
                end
                tail_next[op_q_reg]     = node;
                nonempty_next[op_q_reg] = 1'b1;
            end
            else
            begin
                res_status = ST_FULL;
            end
        end
        else
        begin
            if (!nonempty_reg[op_q_reg])
            begin
                res_status = ST_EMPTY;
            end
            else
            begin
                node    = head_reg[op_q_reg];
                res_key = pop_key_ext;
                if (node == tail_reg[op_q_reg])
                begin
                    nonempty_next[op_q_reg] = 1'b0;
                end
                else
                begin
                    head_next[op_q_reg] = next_rdata;
                end
                next_we         = cmd.exec;
                next_waddr      = node;
                next_wdata      = free_head_reg;
                free_head_next  = node;
                free_count_next = free_count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_QUEUES; i++)
            begin
                head_reg[i] <= '0;
                tail_reg[i] <= '0;
            end
            nonempty_reg    <= '0;
            free_head_reg   <= '0;
            free_count_reg  <= '0;
            fresh_count_reg <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.exec)
            begin
                head_reg        <= head_next;
                tail_reg        <= tail_next;
                nonempty_reg    <= nonempty_next;
                free_head_reg   <= free_head_next;
                free_count_reg  <= free_count_next;
                fresh_count_reg <= fresh_count_next;
                out_valid_reg   <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_func_reg <= func_t'(in_func);
            op_q_reg    <= in_q;
            op_key_reg  <= in_key_kw;
        end
        if (cmd.exec)
        begin
            out_key_reg    <= res_key;
            out_status_reg <= res_status;
        end
    end

    assign stat.out_valid = out_valid_reg;
    assign out_valid      = out_valid_reg;
    assign out_popped_key = out_key_reg;
    assign out_status     = out_status_reg;

endmodule

// ----- hdl/multi_queue_linked_fifo_top.sv -----
// Flow: an accepted request is captured in the operation registers, executed in the
// EXEC state, and its result is held in the output register until taken.
// A new request is not taken while one executes, because of the registered read of
// the node memories (read in the accept cycle, pointer and link update in the next).
// A new request is taken while the previous result still waits, if it drains then.
// Reset: rst_n asynchronous, active low; every queue empty, pool unused, no clear pass.
module multi_queue_linked_fifo_top import mqlf_pkg::*; #(
    parameter int NUM_QUEUES = DEF_NUM_QUEUES,
    parameter int POOL_DEPTH = DEF_POOL_DEPTH,
    parameter int KEY_WIDTH  = DEF_KEY_WIDTH
) (
    input logic            clk,
    input logic            rst_n,
    mqlf_req_if.sink       req,
    mqlf_rsp_if.source     rsp
);

    mqlf_cmd_t  cmd;
    mqlf_stat_t stat;

    mqlf_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (req.valid),
        .in_ready  (req.ready),
        .out_ready (rsp.ready),
        .stat      (stat),
        .cmd       (cmd)
    );

    mqlf_dp #(
        .NUM_QUEUES (NUM_QUEUES),
        .POOL_DEPTH (POOL_DEPTH),
        .KEY_WIDTH  (KEY_WIDTH)
    ) u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .stat           (stat),
        .in_func        (req.func),
        .in_queue_index (req.queue_index),
        .in_key         (req.key),
        .out_ready      (rsp.ready),
        .out_valid      (rsp.valid),
        .out_popped_key (rsp.popped_key),
        .out_status     (rsp.status)
    );

endmodule

// ----- hdl/mqlf_checker.sv -----
module mqlf_checker import mqlf_pkg::*; (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       req_valid,
    input logic                       req_ready,
    input logic                       rsp_valid,
    input logic                       rsp_ready,
    input logic signed [KEY_IN_W-1:0] rsp_popped_key,
    input logic [STATUS_W-1:0]        rsp_status
);

    logic req_acc;

    assign req_acc = req_valid && req_ready;

    a_rsp_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |-> ##2 rsp_valid)
        else $error("no result two cycles after request transaction");

    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        req_acc |=> !req_ready)
        else $error("request taken in back-to-back cycles");

    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (rsp_status == ST_DONE || rsp_status == ST_EMPTY
                       || rsp_status == ST_FULL))
        else $error("undefined status code");

    a_fail_zero_key: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_status != ST_DONE) |-> (rsp_popped_key == '0))
        else $error("failed transaction carries a nonzero key");

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=>
            (rsp_valid && $stable(rsp_popped_key) && $stable(rsp_status)))
        else $error("stalled result changed");

endmodule

bind multi_queue_linked_fifo_top mqlf_checker u_mqlf_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .req_valid      (req.valid),
    .req_ready      (req.ready),
    .rsp_valid      (rsp.valid),
    .rsp_ready      (rsp.ready),
    .rsp_popped_key (rsp.popped_key),
    .rsp_status     (rsp.status)
);

// ----- verif/tb.sv -----
`timescale 1ns / 1ps

module tb import mqlf_pkg::*; ();

    localparam int NQ          = DEF_NUM_QUEUES;
    localparam int PD          = DEF_POOL_DEPTH;
    localparam int PW          = $clog2(PD);
    localparam int HOLD_CYCLES = 300;
    localparam int LIMIT       = 400000;
    localparam int MIX_ITEMS   = 80;
    localparam int SEND_IDLE [4] = '{0, 48, 0, 16};
    localparam int RECV_STALL[4] = '{0, 0, 48, 16};

    typedef struct packed {
        logic signed [KEY_IN_W-1:0] key;
        status_t                    status;
    } outcome_t;

    typedef struct packed {
        func_t               f;
        logic [QIDX_W-1:0]   qi;
        logic [KEY_IN_W-1:0] key;
        logic                typed;
        logic [KEY_IN_W-1:0] exp_key;
        status_t             exp_status;
    } step_row_t;

    // typed rows carry their own expectation, the rest go through the predictor
    localparam step_row_t SCRIPT[23] = '{
        '{FN_POP,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{FN_POP,  4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{FN_PUSH, 4'd0,  32'h7FFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_PUSH, 4'd0,  32'h8000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_PUSH, 4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_PUSH, 4'd15, 32'hFFFF_FFFF, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_POP,  4'd0,  32'h0000_0000, 1'b1, 32'h7FFF_FFFF, ST_DONE},
        '{FN_POP,  4'd15, 32'h0000_0000, 1'b1, 32'hFFFF_FFFF, ST_DONE},
        '{FN_POP,  4'd15, 32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{FN_PUSH, 4'd15, 32'h0000_0001, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_POP,  4'd0,  32'hFFFF_FFFF, 1'b1, 32'h8000_0000, ST_DONE},
        '{FN_PUSH, 4'd0,  32'hAAAA_AAAA, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_POP,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_POP,  4'd0,  32'h0000_0000, 1'b1, 32'hAAAA_AAAA, ST_DONE},
        '{FN_POP,  4'd0,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{FN_PUSH, 4'd7,  32'h5555_5555, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_PUSH, 4'd8,  32'h1234_5678, 1'b1, 32'h0000_0000, ST_DONE},
        '{FN_POP,  4'd8,  32'h0000_0000, 1'b1, 32'h1234_5678, ST_DONE},
        '{FN_POP,  4'd7,  32'h0000_0000, 1'b1, 32'h5555_5555, ST_DONE},
        '{FN_POP,  4'd15, 32'h0000_0000, 1'b1, 32'h0000_0001, ST_DONE},
        '{FN_POP,  4'd7,  32'h0000_0000, 1'b1, 32'h0000_0000, ST_EMPTY},
        '{FN_PUSH, 4'd3,  32'hDEAD_BEEF, 1'b0, 32'h0000_0000, ST_DONE},
        '{FN_PUSH, 4'd3,  32'h0BAD_F00D, 1'b0, 32'h0000_0000, ST_DONE}
    };

    logic clk;
    logic rst_n;

    mqlf_req_if req_ch ();
    mqlf_rsp_if rsp_ch ();

    multi_queue_linked_fifo_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // predictor state
    logic signed [KEY_IN_W-1:0] slot_key  [PD];
    logic [PW-1:0]              slot_link [PD];
    logic [PW-1:0]              head_of   [NQ];
    logic [PW-1:0]              tail_of   [NQ];
    bit                         live      [NQ];
    logic [PW-1:0]              recycle_head;
    int                         recycle_cnt;
    int                         fresh_used;

    outcome_t outcomes_due[$];

    int n_push;
    int n_pop;
    int n_full;
    int n_empty;
    int sent;
    int err_count;
    int send_pct;
    int rcv_pct     = 0;
    int hold_ticket = 0;
    int cycle_count = 0;

    function automatic outcome_t queue_op_outcome(func_t f, logic [QIDX_W-1:0] qi,
                                                  logic signed [KEY_IN_W-1:0] k);
        int       q;
        int       node;
        outcome_t r;
        q        = qi % NQ;
        r.key    = '0;
        r.status = ST_DONE;
        node     = -1;
        if (f == FN_PUSH)
        begin
            if (recycle_cnt > 0)
            begin
                node         = int'(recycle_head);
                recycle_head = slot_link[node];
                recycle_cnt--;
            end
            else if (fresh_used < PD)
            begin
                node = fresh_used;
                fresh_used++;
            end
            if (node < 0)
            begin
                r.status = ST_FULL;
                n_full++;
            end
            else
            begin
                slot_key[node]  = k;
                slot_link[node] = '0;
                if (live[q])
                    slot_link[tail_of[q]] = PW'(node);
                else
                    head_of[q] = PW'(node);
                tail_of[q] = PW'(node);
                live[q]    = 1'b1;
                n_push++;
            end
        end
        else if (!live[q])
        begin
            r.status = ST_EMPTY;
            n_empty++;
        end
        else
        begin
            node  = int'(head_of[q]);
            r.key = slot_key[node];
            if (PW'(node) == tail_of[q])
                live[q] = 1'b0;
            else
                head_of[q] = slot_link[node];
            slot_link[node] = recycle_head;
            recycle_head    = PW'(node);
            recycle_cnt++;
            n_pop++;
        end
        return r;
    endfunction

    function automatic int pick_busy_queue();
        int s;
        s = $urandom_range(NQ - 1);
        for (int i = 0; i < NQ; i++)
            if (live[(s + i) % NQ])
                return (s + i) % NQ;
        return -1;
    endfunction

    function automatic logic [KEY_IN_W-1:0] pick_key();
        case ($urandom_range(9))
            0:       return 32'h7FFF_FFFF;
            1:       return 32'h8000_0000;
            2:       return '0;
            3:       return '1;
            default: return $urandom();
        endcase
    endfunction

    task automatic send_op(func_t f, logic [QIDX_W-1:0] qi, logic signed [KEY_IN_W-1:0] k,
                           bit typed, outcome_t typed_out);
        outcome_t pred;
        req_ch.valid       <= 1'b1;
        req_ch.func        <= f;
        req_ch.queue_index <= qi;
        req_ch.key         <= k;
        do @(posedge clk); while (!req_ch.ready);
        pred = queue_op_outcome(f, qi, k);
        outcomes_due.push_back(typed ? typed_out : pred);
        sent++;
        if ($urandom_range(99) < send_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < send_pct);
        end
    endtask

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    initial
    begin
        int stall_left;
        int hold_seen;
        stall_left   = 0;
        hold_seen    = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_ticket != hold_seen)
            begin
                hold_seen  = hold_ticket;
                stall_left = HOLD_CYCLES;
            end
            if (stall_left > 0)
            begin
                stall_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(99) >= rcv_pct);
        end
    end

    always @(posedge clk)
    begin : check_replies
        outcome_t want;
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (outcomes_due.size() == 0)
            begin
                $display("%0t: unexpected transaction, popped_key=%h status=%0d",
                         $time, rsp_ch.popped_key, rsp_ch.status);
                err_count++;
            end
            else
            begin
                want = outcomes_due.pop_front();
                if (rsp_ch.popped_key !== want.key)
                begin
                    $display("%0t: popped_key expected %h actual %h",
                             $time, want.key, rsp_ch.popped_key);
                    err_count++;
                end
                if (rsp_ch.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, rsp_ch.status);
                    err_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= LIMIT)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    initial
    begin
        int                  b;
        logic [QIDX_W-1:0]   qi;
        outcome_t            tout;
        req_ch.valid       = 1'b0;
        req_ch.func        = FN_PUSH;
        req_ch.queue_index = '0;
        req_ch.key         = '0;
        rst_n              = 1'b0;
        recycle_head       = '0;
        recycle_cnt        = 0;
        fresh_used         = 0;
        n_push             = 0;
        n_pop              = 0;
        n_full             = 0;
        n_empty            = 0;
        sent               = 0;
        err_count          = 0;
        send_pct           = 0;
        foreach (live[i])
        begin
            live[i]    = 1'b0;
            head_of[i] = '0;
            tail_of[i] = '0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;

        foreach (SCRIPT[i])
        begin
            tout.key    = SCRIPT[i].exp_key;
            tout.status = SCRIPT[i].exp_status;
            send_op(SCRIPT[i].f, SCRIPT[i].qi, SCRIPT[i].key, SCRIPT[i].typed, tout);
        end

        // mixed traffic, biased toward a few queues to build long chains
        for (int m = 0; m < 4; m++)
        begin
            send_pct = SEND_IDLE[m];
            rcv_pct <= RECV_STALL[m];
            repeat (MIX_ITEMS)
            begin
                if ($urandom_range(99) < 55)
                begin
                    qi = QIDX_W'($urandom_range(1) ? $urandom_range(3)
                                                   : $urandom_range(NQ - 1));
                    send_op(FN_PUSH, qi, pick_key(), 1'b0, '0);
                end
                else
                begin
                    b  = pick_busy_queue();
                    qi = (b >= 0 && $urandom_range(99) < 80) ? QIDX_W'(b)
                                                              : QIDX_W'($urandom_range(NQ - 1));
                    send_op(FN_POP, qi, $urandom(), 1'b0, '0);
                end
            end
        end

        req_ch.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);

        // fill the pool behind a long output stall, then push into a full pool
        send_pct = 0;
        rcv_pct     <= 0;
        hold_ticket <= hold_ticket + 1;
        while (!(recycle_cnt == 0 && fresh_used == PD))
            send_op(FN_PUSH, QIDX_W'($urandom_range(NQ - 1)), pick_key(), 1'b0, '0);
        repeat (12)
            send_op(FN_PUSH, QIDX_W'($urandom_range(NQ - 1)), pick_key(), 1'b0, '0);

        // drain every queue through the recycled list
        send_pct = SEND_IDLE[3];
        rcv_pct <= RECV_STALL[3];
        forever
        begin
            b = pick_busy_queue();
            if (b < 0)
                break;
            qi = ($urandom_range(99) < 10) ? QIDX_W'($urandom_range(NQ - 1)) : QIDX_W'(b);
            send_op(FN_POP, qi, $urandom(), 1'b0, '0);
        end
        repeat (10)
            send_op(FN_POP, QIDX_W'($urandom_range(NQ - 1)), $urandom(), 1'b0, '0);

        req_ch.valid <= 1'b0;
        while (outcomes_due.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        $display("Ran %0d transactions in %0d cycles: %0d keys stored, %0d keys popped.",
                 sent, cycle_count, n_push, n_pop);
        $display("Pool exhausted %0d times, %0d pops on empty queues, one %0d-cycle output stall.",
                 n_full, n_empty, HOLD_CYCLES);
        if (err_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
